### rtl/vcw_pkg.sv
// vcw_pkg: shared types, codes and reset values for the velocity command watchdog
// no dependencies; imported by every module of the block
`default_nettype none

package vcw_pkg;

	// default field widths
	localparam int VEL_WIDTH_DEF = 16;
	localparam int AGE_WIDTH_DEF = 16;

	// fixed register widths
	localparam int TICK_WIDTH      = 16;
	localparam int LIMIT_WIDTH     = 15;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	// register reset values
	localparam logic [TICK_WIDTH-1:0]  TIMEOUT_RST   = 16'd650;
	localparam logic [TICK_WIDTH-1:0]  DEBOUNCE_RST  = 16'd120;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_X_RST   = 15'd4096;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_Y_RST   = 15'd2048;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_YAW_RST = 15'd6144;

	typedef enum logic [1:0] {
		REQ_COMMAND = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_SEND    = 2'd2
	} req_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_TIMEOUT   = 3'd0,
		CFG_DEBOUNCE  = 3'd1,
		CFG_LIMIT_X   = 3'd2,
		CFG_LIMIT_Y   = 3'd3,
		CFG_LIMIT_YAW = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [TICK_WIDTH-1:0]  timeout_ticks;
		logic [TICK_WIDTH-1:0]  debounce_ticks;
		logic [LIMIT_WIDTH-1:0] limit_x;
		logic [LIMIT_WIDTH-1:0] limit_y;
		logic [LIMIT_WIDTH-1:0] limit_yaw;
	} cfg_t;

	typedef struct packed {
		logic timed_out;
		logic held;
	} flags_t;

endpackage

`default_nettype wire

### rtl/vcw_cfg.sv
// vcw_cfg: configuration register file (timeout, debounce, three clamp limits)
// depends on vcw_pkg
`default_nettype none

module vcw_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [vcw_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
	input  logic [vcw_pkg::CFG_DATA_WIDTH-1:0]   wr_data,
	output vcw_pkg::cfg_t                        cfg
);
	import vcw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks  <= TIMEOUT_RST;
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.limit_x        <= LIMIT_X_RST;
			cfg_q.limit_y        <= LIMIT_Y_RST;
			cfg_q.limit_yaw      <= LIMIT_YAW_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_TIMEOUT:   cfg_q.timeout_ticks  <= wr_data[TICK_WIDTH-1:0];
				CFG_DEBOUNCE:  cfg_q.debounce_ticks <= wr_data[TICK_WIDTH-1:0];
				CFG_LIMIT_X:   cfg_q.limit_x        <= wr_data[LIMIT_WIDTH-1:0];
				CFG_LIMIT_Y:   cfg_q.limit_y        <= wr_data[LIMIT_WIDTH-1:0];
				CFG_LIMIT_YAW: cfg_q.limit_yaw      <= wr_data[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/vcw_clamp.sv
// vcw_clamp: clamps one signed velocity to [-limit, +limit]
// depends on vcw_pkg
`default_nettype none

module vcw_clamp #(
	parameter int VEL_WIDTH = vcw_pkg::VEL_WIDTH_DEF
) (
	input  logic signed [VEL_WIDTH-1:0]          v,
	input  logic [vcw_pkg::LIMIT_WIDTH-1:0]      limit,
	output logic signed [VEL_WIDTH-1:0]          y
);
	import vcw_pkg::*;

	// wide enough for the velocity and the negated limit
	localparam int CW = ((VEL_WIDTH > LIMIT_WIDTH + 1) ? VEL_WIDTH : LIMIT_WIDTH + 1) + 1;

	logic signed [CW-1:0] v_ext;
	logic signed [CW-1:0] lim_pos;
	logic signed [CW-1:0] lim_neg;

	always_comb begin
		v_ext   = CW'(v);
		lim_pos = signed'(CW'(limit));
		lim_neg = -lim_pos;
		if (v_ext > lim_pos) begin
			y = lim_pos[VEL_WIDTH-1:0];
		end else if (v_ext < lim_neg) begin
			y = lim_neg[VEL_WIDTH-1:0];
		end else begin
			y = v;
		end
	end

endmodule

`default_nettype wire

### rtl/vcw_state.sv
// vcw_state: command store, saturating ages, stale and debounce decisions
// depends on vcw_pkg; selected velocities go to vcw_clamp in the top level
`default_nettype none

module vcw_state #(
	parameter int VEL_WIDTH = vcw_pkg::VEL_WIDTH_DEF,
	parameter int AGE_WIDTH = vcw_pkg::AGE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [1:0]                    req,
	input  logic signed [VEL_WIDTH-1:0]   vel [3],
	input  vcw_pkg::cfg_t                 cfg,
	output logic signed [VEL_WIDTH-1:0]   sel_vel [3],
	output vcw_pkg::flags_t               flags
);
	import vcw_pkg::*;

	localparam int CMPW = (AGE_WIDTH > TICK_WIDTH) ? AGE_WIDTH : TICK_WIDTH;
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

	logic                        have_cmd_q;
	logic [AGE_WIDTH-1:0]        cmd_age_q;
	logic signed [VEL_WIDTH-1:0] last_vel_q [3];
	logic                        zr_valid_q;
	logic [AGE_WIDTH-1:0]        zr_age_q;
	logic signed [VEL_WIDTH-1:0] last_nz_q [3];

	logic in_zero;
	logic last_zero;
	logic nz_zero;
	logic stale;
	logic hold_ok;

	assign in_zero   = (vel[0] == '0) && (vel[1] == '0) && (vel[2] == '0);
	assign last_zero = (last_vel_q[0] == '0) && (last_vel_q[1] == '0) && (last_vel_q[2] == '0);
	assign nz_zero   = (last_nz_q[0] == '0) && (last_nz_q[1] == '0) && (last_nz_q[2] == '0);

	// age equal to the timeout is still fresh
	assign stale   = !have_cmd_q || (CMPW'(cmd_age_q) > CMPW'(cfg.timeout_ticks));
	assign hold_ok = zr_valid_q && (CMPW'(zr_age_q) < CMPW'(cfg.debounce_ticks)) && !nz_zero;

	always_comb begin
		flags.timed_out = 1'b0;
		flags.held      = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sel_vel[i] = '0;
		end
		if (stale) begin
			flags.timed_out = 1'b1;
		end else if (!last_zero) begin
			for (int i = 0; i < 3; i++) begin
				sel_vel[i] = last_vel_q[i];
			end
		end else if (hold_ok) begin
			flags.held = 1'b1;
			for (int i = 0; i < 3; i++) begin
				sel_vel[i] = last_nz_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_cmd_q <= 1'b0;
			cmd_age_q  <= '0;
			zr_valid_q <= 1'b0;
			zr_age_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				last_vel_q[i] <= '0;
				last_nz_q[i]  <= '0;
			end
		end else if (step_en) begin
			case (req)
				REQ_COMMAND: begin
					have_cmd_q <= 1'b1;
					cmd_age_q  <= '0;
					for (int i = 0; i < 3; i++) begin
						last_vel_q[i] <= vel[i];
					end
					if (!in_zero) begin
						zr_valid_q <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							last_nz_q[i] <= vel[i];
						end
					end else if (!zr_valid_q) begin
						// start of a zero run
						zr_valid_q <= 1'b1;
						zr_age_q   <= '0;
					end
				end
				REQ_TICK: begin
					if (cmd_age_q != AGE_MAX) cmd_age_q <= cmd_age_q + 1'b1;
					if (zr_age_q != AGE_MAX)  zr_age_q  <= zr_age_q + 1'b1;
				end
				REQ_SEND: begin
					if (stale) zr_valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	a_tick_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && req == REQ_TICK |=> cmd_age_q >= $past(cmd_age_q))
		else $error("command age wrapped on a tick");

	a_command_clears_age: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && req == REQ_COMMAND |=> have_cmd_q && cmd_age_q == '0)
		else $error("command did not restart the age");

endmodule

`default_nettype wire

### rtl/velocity_command_watchdog_core.sv
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------
// request   | in        | in_valid / in_ready   | req_type, vel_x, vel_y, yaw_rate
// drive     | out       | out_valid / out_ready | out_x, out_y, out_yaw, timed_out, held
// config    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while no send is stalled; a send item passes through the
// input register, then the state update and clamp into the result register
// command and tick items give no result and never wait on the drive channel
// a send item waits in the input register while an earlier result is not taken
// reset clears the valid flags and watchdog state and loads the register defaults; cfg_ready is always high
//
// depends on vcw_pkg, vcw_cfg, vcw_state, vcw_clamp
`default_nettype none

module velocity_command_watchdog_core #(
	parameter int VEL_WIDTH = vcw_pkg::VEL_WIDTH_DEF,
	parameter int AGE_WIDTH = vcw_pkg::AGE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           req_type,
	input  logic signed [VEL_WIDTH-1:0]          vel_x,
	input  logic signed [VEL_WIDTH-1:0]          vel_y,
	input  logic signed [VEL_WIDTH-1:0]          yaw_rate,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [VEL_WIDTH-1:0]          out_x,
	output logic signed [VEL_WIDTH-1:0]          out_y,
	output logic signed [VEL_WIDTH-1:0]          out_yaw,
	output logic                                 timed_out,
	output logic                                 held,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vcw_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [vcw_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import vcw_pkg::*;

	cfg_t cfg;

	logic                        valid_s1;
	logic [1:0]                  req_s1;
	logic signed [VEL_WIDTH-1:0] vel_s1 [3];
	logic                        advance_s1;
	logic                        send_s1;

	logic signed [VEL_WIDTH-1:0] sel_vel [3];
	logic signed [VEL_WIDTH-1:0] clamp_vel [3];
	flags_t                      flags;

	logic                        out_valid_q;
	logic signed [VEL_WIDTH-1:0] out_vel_q [3];
	flags_t                      out_flags_q;

	assign cfg_ready = 1'b1;

	vcw_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// only a send needs room in the result register
	assign send_s1    = (req_s1 == REQ_SEND);
	assign advance_s1 = valid_s1 && (!send_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1    <= req_type;
			vel_s1[0] <= vel_x;
			vel_s1[1] <= vel_y;
			vel_s1[2] <= yaw_rate;
		end
	end

	vcw_state #(
		.VEL_WIDTH (VEL_WIDTH),
		.AGE_WIDTH (AGE_WIDTH)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance_s1),
		.req     (req_s1),
		.vel     (vel_s1),
		.cfg     (cfg),
		.sel_vel (sel_vel),
		.flags   (flags)
	);

	vcw_clamp #(.VEL_WIDTH(VEL_WIDTH)) u_clamp_x (
		.v (sel_vel[0]), .limit (cfg.limit_x), .y (clamp_vel[0])
	);
	vcw_clamp #(.VEL_WIDTH(VEL_WIDTH)) u_clamp_y (
		.v (sel_vel[1]), .limit (cfg.limit_y), .y (clamp_vel[1])
	);
	vcw_clamp #(.VEL_WIDTH(VEL_WIDTH)) u_clamp_yaw (
		.v (sel_vel[2]), .limit (cfg.limit_yaw), .y (clamp_vel[2])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && send_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && send_s1) begin
			out_vel_q   <= clamp_vel;
			out_flags_q <= flags;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_vel_q[0];
	assign out_y     = out_vel_q[1];
	assign out_yaw   = out_vel_q[2];
	assign timed_out = out_flags_q.timed_out;
	assign held      = out_flags_q.held;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_flags_q.timed_out && out_flags_q.held))
		else $error("timed_out and held both set");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_flags_q.timed_out |-> out_vel_q[0] == '0 &&
			out_vel_q[1] == '0 && out_vel_q[2] == '0)
		else $error("timed out result is not zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && send_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked send");

endmodule

`default_nettype wire
